FILE: hw/rtl/lcgo_pkg.sv
// Shared types, codes and helpers for the line crossing grid odometer.
package lcgo_pkg;

   localparam int unsigned SAMPLE_W = 10;
   localparam int unsigned WAIT_W   = 16;
   localparam int unsigned POS_W    = 16;
   localparam int unsigned SM_W     = 8;

   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 10'd512;
   localparam logic [WAIT_W-1:0]   WAIT_RESET      = 16'd20;

   localparam logic [SM_W-1:0] SM_SIGN = 8'h80;
   localparam logic [SM_W-2:0] SM_MAX  = 7'h7f;

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_TICK   = 2'd1,
      OP_TURN   = 2'd2,
      OP_LOAD   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PH_NOPUSH          = 2'd0,
      PH_MAYBE           = 2'd1,
      PH_MAYBE_FROM_PUSH = 2'd2,
      PH_PUSHED          = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      HEAD_UP    = 2'd0,
      HEAD_RIGHT = 2'd1,
      HEAD_DOWN  = 2'd2,
      HEAD_LEFT  = 2'd3
   } heading_type;

   typedef enum logic {
      REG_THRESHOLD = 1'b0,
      REG_WAIT      = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] threshold_code;
      logic [WAIT_W-1:0]   wait_reload;
   } cfg_type;

   typedef struct packed {
      op_type                  operation;
      logic [SAMPLE_W-1:0]     sample_code;
      logic                    turn_right;
      logic signed [POS_W-1:0] load_x;
      logic signed [POS_W-1:0] load_y;
      logic [1:0]              load_heading;
   } item_type;

   typedef struct packed {
      logic                    line_present;
      logic                    crossing_counted;
      logic [1:0]              heading;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic [SM_W-1:0]         pos_x_signmag;
      logic [SM_W-1:0]         pos_y_signmag;
   } result_type;

   // sign bit plus magnitude clamped to 127
   function automatic logic [SM_W-1:0] sign_mag(input logic signed [POS_W-1:0] v);
      logic [POS_W-1:0] neg;
      logic [SM_W-1:0]  res;
      neg = POS_W'(-v);
      if (v[POS_W-1]) begin
         if (v < -16'sd127) res = SM_SIGN | {1'b0, SM_MAX};
         else res = SM_SIGN | {1'b0, neg[SM_W-2:0]};
      end else begin
         if (v > 16'sd127) res = {1'b0, SM_MAX};
         else res = {1'b0, v[SM_W-2:0]};
      end
      return res;
   endfunction

endpackage

FILE: hw/rtl/lcgo_csr.sv
// APB-style register file: sensor threshold and debounce wait.
module lcgo_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output lcgo_pkg::cfg_type    cfg
);

   logic [lcgo_pkg::SAMPLE_W-1:0] threshold_ff;
   logic [lcgo_pkg::SAMPLE_W-1:0] threshold_in;
   logic [lcgo_pkg::WAIT_W-1:0]   wait_ff;
   logic [lcgo_pkg::WAIT_W-1:0]   wait_in;
   logic                          wr_en;
   lcgo_pkg::reg_index_type       idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   // word-aligned decode; low address bits are ignored
   assign idx        = lcgo_pkg::reg_index_type'(csr_paddr[2]);

   always_comb begin
      threshold_in = threshold_ff;
      wait_in      = wait_ff;
      if (wr_en) begin
         case (idx)
            lcgo_pkg::REG_THRESHOLD: threshold_in = csr_pwdata[lcgo_pkg::SAMPLE_W-1:0];
            lcgo_pkg::REG_WAIT:      wait_in      = csr_pwdata[lcgo_pkg::WAIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= lcgo_pkg::THRESHOLD_RESET;
         wait_ff      <= lcgo_pkg::WAIT_RESET;
      end else begin
         threshold_ff <= threshold_in;
         wait_ff      <= wait_in;
      end
   end

   always_comb begin
      case (idx)
         lcgo_pkg::REG_THRESHOLD: csr_prdata = 32'(threshold_ff);
         lcgo_pkg::REG_WAIT:      csr_prdata = 32'(wait_ff);
         default:                 csr_prdata = 32'd0;
      endcase
   end

   assign cfg.threshold_code = threshold_ff;
   assign cfg.wait_reload    = wait_ff;

endmodule

FILE: hw/rtl/lcgo_core.sv
// Odometer state: debounce machine, wait counter, heading and grid position.
module lcgo_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  lcgo_pkg::item_type    item,
   input  lcgo_pkg::cfg_type     cfg,
   output lcgo_pkg::result_type  result
);

   lcgo_pkg::phase_type             phase_ff, phase_in;
   logic                            deb_ff, deb_in;
   logic                            handled_ff, handled_in;
   logic [lcgo_pkg::WAIT_W-1:0]     wait_ff, wait_in;
   logic [1:0]                      head_ff, head_in;
   logic signed [lcgo_pkg::POS_W-1:0] x_ff, x_in;
   logic signed [lcgo_pkg::POS_W-1:0] y_ff, y_in;
   logic                            line;
   logic                            crossed;

   assign line = item.sample_code > cfg.threshold_code;

   always_comb begin
      phase_in   = phase_ff;
      deb_in     = deb_ff;
      handled_in = handled_ff;
      wait_in    = wait_ff;
      head_in    = head_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      crossed    = 1'b0;
      case (item.operation)
         lcgo_pkg::OP_SAMPLE: begin
            if (wait_ff == '0) begin
               wait_in = cfg.wait_reload;
               case (phase_ff)
                  lcgo_pkg::PH_NOPUSH: begin
                     phase_in = line ? lcgo_pkg::PH_MAYBE : lcgo_pkg::PH_NOPUSH;
                  end
                  lcgo_pkg::PH_MAYBE: begin
                     if (line) begin
                        phase_in   = lcgo_pkg::PH_PUSHED;
                        deb_in     = 1'b1;
                        handled_in = 1'b0;
                     end else begin
                        phase_in = lcgo_pkg::PH_NOPUSH;
                        deb_in   = 1'b0;
                     end
                  end
                  lcgo_pkg::PH_MAYBE_FROM_PUSH: begin
                     if (line) begin
                        phase_in = lcgo_pkg::PH_PUSHED;
                     end else begin
                        phase_in = lcgo_pkg::PH_NOPUSH;
                        deb_in   = 1'b0;
                     end
                  end
                  default: begin
                     phase_in = line ? lcgo_pkg::PH_PUSHED : lcgo_pkg::PH_MAYBE_FROM_PUSH;
                  end
               endcase
            end
            // a pending crossing counts even while the machine holds
            if (deb_in && !handled_in) begin
               handled_in = 1'b1;
               crossed    = 1'b1;
               case (lcgo_pkg::heading_type'(head_ff))
                  lcgo_pkg::HEAD_UP:    y_in = y_ff + 16'sd1;
                  lcgo_pkg::HEAD_RIGHT: x_in = x_ff + 16'sd1;
                  lcgo_pkg::HEAD_DOWN:  y_in = y_ff - 16'sd1;
                  default:              x_in = x_ff - 16'sd1;
               endcase
            end
         end
         lcgo_pkg::OP_TICK: begin
            if (wait_ff != '0) wait_in = wait_ff - 16'd1;
         end
         lcgo_pkg::OP_TURN: begin
            head_in = item.turn_right ? head_ff + 2'd1 : head_ff - 2'd1;
         end
         default: begin
            x_in    = item.load_x;
            y_in    = item.load_y;
            head_in = item.load_heading;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= lcgo_pkg::PH_NOPUSH;
         deb_ff     <= 1'b0;
         handled_ff <= 1'b0;
         wait_ff    <= '0;
         head_ff    <= 2'd0;
         x_ff       <= '0;
         y_ff       <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         deb_ff     <= deb_in;
         handled_ff <= handled_in;
         wait_ff    <= wait_in;
         head_ff    <= head_in;
         x_ff       <= x_in;
         y_ff       <= y_in;
      end
   end

   assign result.line_present     = deb_in;
   assign result.crossing_counted = crossed;
   assign result.heading          = head_in;
   assign result.pos_x            = x_in;
   assign result.pos_y            = y_in;
   assign result.pos_x_signmag    = lcgo_pkg::sign_mag(x_in);
   assign result.pos_y_signmag    = lcgo_pkg::sign_mag(y_in);

endmodule

FILE: hw/rtl/line_crossing_grid_odometer.sv
// Top level of the line crossing grid odometer: stream ports, staging and CSRs.
//
// Usage:
//  - req_* carries one input word per handshake; req_tuser holds the operation
//    (sample, tick, turn, load) and req_tdata the operand fields.
//  - rsp_* returns exactly one result word for every accepted input word, in
//    order: debounced line flag, crossing pulse, heading, X/Y position and the
//    saturated sign-magnitude bytes of X and Y.
//  - csr_* is an APB-style port: threshold at 0x0, debounce wait at 0x4.
//    Write it only while no words are in flight.
// Timing:
//  - A word lands in the input register, then the odometer update runs in the
//    cycle that moves it into the result register, which drives rsp_tvalid.
//  - Throughput is one word per cycle while rsp_tready stays high; the only loop
//    is the state update of the debounce machine, wait counter and position.
//  - When rsp_tready is low the result register holds, the input register
//    still fills once, then req_tready drops until the result drains.
// Reset (synchronous): both stages empty, threshold 512, wait 20, debounce
// machine idle, counter zero, heading up, position at the origin.
module line_crossing_grid_odometer (
   input  logic        clock,
   input  logic        reset,
   // req_tdata from bit 0 up: sample_code[9:0], turn_right, load_x[15:0],
   // load_y[15:0], load_heading[1:0], zero fill
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   // req_tuser: operation[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rsp_tdata from bit 0 up: line_present, crossing_counted, heading[1:0],
   // pos_x[15:0], pos_y[15:0], pos_x_signmag[7:0], pos_y_signmag[7:0], zero fill
   output logic [55:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   lcgo_pkg::cfg_type    cfg;
   lcgo_pkg::item_type   item_ff, item_in;
   lcgo_pkg::result_type result;
   lcgo_pkg::result_type rsp_ff;
   logic                 in_valid_ff, in_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 req_fire;
   logic                 advance;

   lcgo_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // staged word moves into the result register when that slot frees up
   assign advance    = in_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign req_fire   = req_tvalid & req_tready;

   always_comb begin
      item_in.operation    = lcgo_pkg::op_type'(req_tuser);
      item_in.sample_code  = req_tdata[9:0];
      item_in.turn_right   = req_tdata[10];
      item_in.load_x       = req_tdata[26:11];
      item_in.load_y       = req_tdata[42:27];
      item_in.load_heading = req_tdata[44:43];
   end

   assign in_valid_in  = req_fire | (in_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_tready);

   lcgo_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) item_ff <= item_in;
      if (advance)  rsp_ff  <= result;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0,
                        rsp_ff.pos_y_signmag,
                        rsp_ff.pos_x_signmag,
                        rsp_ff.pos_y,
                        rsp_ff.pos_x,
                        rsp_ff.heading,
                        rsp_ff.crossing_counted,
                        rsp_ff.line_present};

   // a counted crossing only happens with the debounced flag set
   a_cross_needs_line: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[0])
      else $error("crossing reported without debounced line");

   // sign-magnitude sign follows the two's complement sign
   a_signmag_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[43] == rsp_tdata[19]) && (rsp_tdata[51] == rsp_tdata[35]))
      else $error("sign-magnitude sign mismatch");

   // nothing comes out and the input side is ready in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("stages not empty after reset");

   // an empty staging register always takes a word
   a_stage_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("ready low with empty staging register");

endmodule

FILE: bench/lcgo_tb_pkg.sv
// Scoreboard class for the line crossing grid odometer bench: state predictor and result checker.
package lcgo_tb_pkg;
   import lcgo_pkg::*;

   class odometer_scoreboard;
      logic [SAMPLE_W-1:0]     threshold   = THRESHOLD_RESET;
      logic [WAIT_W-1:0]       wait_reload = WAIT_RESET;
      phase_type               phase       = PH_NOPUSH;
      logic                    line_flag   = 1'b0;
      logic                    handled     = 1'b0;
      logic [WAIT_W-1:0]       wait_left   = '0;
      heading_type             head        = HEAD_UP;
      logic signed [POS_W-1:0] pos_x       = '0;
      logic signed [POS_W-1:0] pos_y       = '0;
      result_type              expected_poses[$];
      int unsigned             errors      = 0;

      function void set_register(reg_index_type idx, logic [31:0] value);
         if (idx == REG_THRESHOLD) threshold = value[SAMPLE_W-1:0];
         else wait_reload = value[WAIT_W-1:0];
      endfunction

      function logic [SM_W-1:0] to_signmag(logic signed [POS_W-1:0] v);
         logic [POS_W-1:0] mag;
         mag = v[POS_W-1] ? POS_W'(-v) : POS_W'(v);
         if (mag > SM_MAX) mag = SM_MAX;
         return {v[POS_W-1], mag[SM_W-2:0]};
      endfunction

      // advance the odometer by one accepted word and queue the pose it must report
      function void note_request(item_type it);
         result_type want;
         logic       on_line;
         want = '0;
         case (it.operation)
            OP_SAMPLE: begin
               on_line = it.sample_code > threshold;
               if (wait_left == '0) begin
                  case (phase)
                     PH_NOPUSH: phase = on_line ? PH_MAYBE : PH_NOPUSH;
                     PH_MAYBE: begin
                        if (on_line) begin
                           phase     = PH_PUSHED;
                           line_flag = 1'b1;
                           handled   = 1'b0;
                        end else begin
                           phase     = PH_NOPUSH;
                           line_flag = 1'b0;
                        end
                     end
                     PH_MAYBE_FROM_PUSH: begin
                        if (on_line) begin
                           phase = PH_PUSHED;
                        end else begin
                           phase     = PH_NOPUSH;
                           line_flag = 1'b0;
                        end
                     end
                     default: phase = on_line ? PH_PUSHED : PH_MAYBE_FROM_PUSH;
                  endcase
                  wait_left = wait_reload;
               end
               if (line_flag && !handled) begin
                  handled               = 1'b1;
                  want.crossing_counted = 1'b1;
                  case (head)
                     HEAD_UP:    pos_y = pos_y + 16'sd1;
                     HEAD_RIGHT: pos_x = pos_x + 16'sd1;
                     HEAD_DOWN:  pos_y = pos_y - 16'sd1;
                     default:    pos_x = pos_x - 16'sd1;
                  endcase
               end
            end
            OP_TICK: if (wait_left != '0) wait_left = wait_left - 1'b1;
            OP_TURN: begin
               if (it.turn_right) head = heading_type'(2'(head + 2'd1));
               else head = heading_type'(2'(head - 2'd1));
            end
            default: begin
               pos_x = it.load_x;
               pos_y = it.load_y;
               head  = heading_type'(it.load_heading);
            end
         endcase
         want.line_present  = line_flag;
         want.heading       = head;
         want.pos_x         = pos_x;
         want.pos_y         = pos_y;
         want.pos_x_signmag = to_signmag(pos_x);
         want.pos_y_signmag = to_signmag(pos_y);
         expected_poses.push_back(want);
      endfunction

      function void field_ok(string name, logic [15:0] want, logic [15:0] seen);
         if (want !== seen) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, seen);
            errors++;
         end
      endfunction

      function void check_response(result_type seen);
         result_type want;
         if (expected_poses.size() == 0) begin
            $display("%0t: unexpected result word, expected none actual %h", $time, seen);
            errors++;
            return;
         end
         want = expected_poses.pop_front();
         field_ok("line_present", 16'(want.line_present), 16'(seen.line_present));
         field_ok("crossing_counted", 16'(want.crossing_counted), 16'(seen.crossing_counted));
         field_ok("heading", 16'(want.heading), 16'(seen.heading));
         field_ok("pos_x", want.pos_x, seen.pos_x);
         field_ok("pos_y", want.pos_y, seen.pos_y);
         field_ok("pos_x_signmag", 16'(want.pos_x_signmag), 16'(seen.pos_x_signmag));
         field_ok("pos_y_signmag", 16'(want.pos_y_signmag), 16'(seen.pos_y_signmag));
      endfunction

      function int unsigned outstanding();
         return expected_poses.size();
      endfunction
   endclass

endpackage

FILE: bench/tb_line_crossing_grid_odometer.sv
// Self-checking bench for the line crossing grid odometer: directed and random stream traffic.
module tb_line_crossing_grid_odometer;
   import lcgo_pkg::*;
   import lcgo_tb_pkg::*;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   // req_tdata from bit 0 up: sample_code[9:0], turn_right, load_x[15:0],
   // load_y[15:0], load_heading[1:0], zero fill
   logic [47:0] req_tdata   = '0;
   // req_tuser: operation[1:0]
   logic [1:0]  req_tuser   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   // rsp_tdata from bit 0 up: line_present, crossing_counted, heading[1:0],
   // pos_x[15:0], pos_y[15:0], pos_x_signmag[7:0], pos_y_signmag[7:0], zero fill
   logic [55:0] rsp_tdata;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // idle odds in percent per cycle, changed between phases
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   odometer_scoreboard scoreboard = new();
   result_type         seen_pose;

   line_crossing_grid_odometer u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: values seen at the edge are the pre-edge ones, so the
   // handshake is judged on what the block actually presented
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_pose.line_present     = rsp_tdata[0];
         seen_pose.crossing_counted = rsp_tdata[1];
         seen_pose.heading          = rsp_tdata[3:2];
         seen_pose.pos_x            = rsp_tdata[19:4];
         seen_pose.pos_y            = rsp_tdata[35:20];
         seen_pose.pos_x_signmag    = rsp_tdata[43:36];
         seen_pose.pos_y_signmag    = rsp_tdata[51:44];
         scoreboard.check_response(seen_pose);
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // every field random, so unused operand bits toggle too
   function automatic item_type random_item(op_type op);
      item_type it;
      it.operation    = op;
      it.sample_code  = SAMPLE_W'($urandom);
      it.turn_right   = 1'($urandom);
      it.load_x       = POS_W'($urandom);
      it.load_y       = POS_W'($urandom);
      it.load_heading = 2'($urandom);
      return it;
   endfunction

   // coordinates biased to the wrap points and the saturation knee
   function automatic logic [POS_W-1:0] pick_coordinate();
      case ($urandom_range(3))
         0:       return POS_W'($urandom);
         1:       return 16'h8000 + POS_W'($urandom_range(3));
         2:       return 16'h7fff - POS_W'($urandom_range(3));
         default: return POS_W'($urandom_range(260)) - 16'd130;
      endcase
   endfunction

   // one word per call; optional random gap first, valid stays up across
   // back-to-back calls so there is one assignment per time step
   task automatic send_word(input item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.operation;
      req_tdata  <= {3'b000, it.load_heading, it.load_y, it.load_x, it.turn_right,
                     it.sample_code};
      do @(posedge clock); while (!req_tready);
      scoreboard.note_request(it);
   endtask

   // a: sample code / turn direction / X, b: Y, c: heading (load only)
   task automatic send_directed(input op_type op, input logic [15:0] a, input logic [15:0] b,
                                input logic [1:0] c);
      item_type it;
      it = random_item(op);
      case (op)
         OP_SAMPLE: it.sample_code = a[SAMPLE_W-1:0];
         OP_TURN:   it.turn_right  = a[0];
         OP_LOAD: begin
            it.load_x       = a;
            it.load_y       = b;
            it.load_heading = c;
         end
         default: ;
      endcase
      send_word(it);
   endtask

   // hold off until every result is back, then let the pipe settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (scoreboard.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // setup cycle then access cycle; the register takes the value on the access edge,
   // then the bus idles before return so back-to-back writes never collide in one time step
   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      scoreboard.set_register(idx, value);
   endtask

   // random traffic, mostly whole line passes so the debounce machine goes
   // through all its phases; the rest is turns, loads, ticks and noise
   task automatic run_traffic(input int unsigned budget);
      int unsigned sent;
      int unsigned pick;
      int unsigned thr;
      int unsigned reload;
      int unsigned on_len;
      int unsigned off_len;
      int unsigned ticks;
      item_type    it;
      sent   = 0;
      thr    = 32'(scoreboard.threshold);
      reload = 32'(scoreboard.wait_reload);
      while (sent < budget) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            on_len  = $urandom_range(4, 1);
            off_len = $urandom_range(4, 1);
            for (int s = 0; s < on_len + off_len; s++) begin
               // reload of 8 or less: ticks to run the counter down, now and then one short
               if (reload <= 8) begin
                  ticks = reload;
                  if (ticks != 0 && $urandom_range(7) == 0) ticks--;
               end else begin
                  ticks = $urandom_range(3);
               end
               repeat (ticks) begin
                  send_word(random_item(OP_TICK));
                  sent++;
               end
               it = random_item(OP_SAMPLE);
               if (s < on_len) begin
                  it.sample_code = (thr < 1023) ? SAMPLE_W'($urandom_range(1023, thr + 1))
                                                : SAMPLE_W'(1023);
               end else begin
                  it.sample_code = SAMPLE_W'($urandom_range(thr, 0));
               end
               send_word(it);
               sent++;
            end
         end else if (pick < 70) begin
            send_word(random_item(OP_TURN));
            sent++;
         end else if (pick < 76) begin
            it        = random_item(OP_LOAD);
            it.load_x = pick_coordinate();
            it.load_y = pick_coordinate();
            send_word(it);
            sent++;
         end else if (pick < 86) begin
            repeat ($urandom_range(4, 1)) begin
               send_word(random_item(OP_TICK));
               sent++;
            end
         end else begin
            send_word(random_item(op_type'($urandom_range(3))));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero wait so every sample moves the debounce machine
      csr_write(REG_THRESHOLD, 32'd512);
      csr_write(REG_WAIT, 32'd0);
      send_directed(OP_LOAD, 16'h7fff, 16'h8000, HEAD_RIGHT);  // both saturations
      send_directed(OP_SAMPLE, 16'd512, '0, '0);               // equal to threshold: floor
      send_directed(OP_SAMPLE, 16'd513, '0, '0);               // maybe
      send_directed(OP_SAMPLE, 16'd1023, '0, '0);              // pushed, X wraps to 0x8000
      send_directed(OP_SAMPLE, 16'd0, '0, '0);                 // maybe from push
      send_directed(OP_SAMPLE, 16'd1023, '0, '0);              // back to pushed, no recount
      send_directed(OP_SAMPLE, 16'd0, '0, '0);
      send_directed(OP_SAMPLE, 16'd0, '0, '0);                 // released
      send_directed(OP_TICK, '0, '0, '0);                      // counter already zero
      send_directed(OP_TURN, 16'd1, '0, '0);
      send_directed(OP_TURN, 16'd1, '0, '0);
      send_directed(OP_TURN, 16'd1, '0, '0);                   // left wraps to up
      send_directed(OP_TURN, 16'd0, '0, '0);
      send_directed(OP_TURN, 16'd0, '0, '0);                   // down
      send_directed(OP_SAMPLE, 16'd1023, '0, '0);
      send_directed(OP_SAMPLE, 16'd1023, '0, '0);              // Y wraps 0x8000 -> 0x7fff
      send_directed(OP_LOAD, 16'hffff, 16'h0080, HEAD_LEFT);
      send_directed(OP_SAMPLE, 16'd0, '0, '0);
      send_directed(OP_SAMPLE, 16'd0, '0, '0);
      send_directed(OP_SAMPLE, 16'd1023, '0, '0);
      send_directed(OP_SAMPLE, 16'd1023, '0, '0);              // step left to -2
      send_directed(OP_LOAD, 16'h0000, 16'hff81, HEAD_UP);
      send_directed(OP_TICK, '0, '0, '0);
      send_directed(OP_SAMPLE, 16'd0, '0, '0);
      drain();

      // random phases: settings move between extremes, idling per phase
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin
               csr_write(REG_THRESHOLD, 32'd0);
               csr_write(REG_WAIT, 32'd0);
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               run_traffic(80);
            end
            1: begin
               csr_write(REG_THRESHOLD, 32'd1023);
               csr_write(REG_WAIT, 32'd65535);
               send_idle_pct  = 63;
               recv_stall_pct = 0;
               run_traffic(25);
            end
            2: begin
               csr_write(REG_THRESHOLD, 32'd300);
               csr_write(REG_WAIT, 32'd2);
               send_idle_pct  = 63;
               recv_stall_pct = 0;
               run_traffic(80);
            end
            3: begin
               csr_write(REG_THRESHOLD, 32'd700);
               csr_write(REG_WAIT, 32'd1);
               send_idle_pct  = 0;
               recv_stall_pct = 63;
               run_traffic(90);
            end
            4: begin
               csr_write(REG_THRESHOLD, 32'd512);
               csr_write(REG_WAIT, 32'd3);
               send_idle_pct  = 22;
               recv_stall_pct = 22;
               run_traffic(90);
            end
            default: begin
               csr_write(REG_THRESHOLD, 32'd900);
               csr_write(REG_WAIT, 32'd0);
               send_idle_pct  = 22;
               recv_stall_pct = 22;
               run_traffic(85);
            end
         endcase
         drain();
      end

      if (scoreboard.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #3000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/lcgo_pkg.sv
hw/rtl/lcgo_csr.sv
hw/rtl/lcgo_core.sv
hw/rtl/line_crossing_grid_odometer.sv
bench/lcgo_tb_pkg.sv
bench/tb_line_crossing_grid_odometer.sv
